FILE: sv/dhe_pkg.sv
// Shared types and constants for the depth histogram equalizer.
// No dependencies; imported by every module of the block.
package dhe_pkg;

	localparam int DEPTH_BINS = 16384;
	localparam int COUNT_BITS = 20;
	localparam int ADDR_W     = $clog2(DEPTH_BINS);
	localparam int LIM_W      = $clog2(DEPTH_BINS + 1);
	localparam int CFG_W      = 15;
	localparam int DEPTH_W    = 14;
	localparam int CMP_W      = (LIM_W > CFG_W) ? LIM_W : CFG_W;
	localparam int INTENS_W   = 9;
	localparam int STEP_W     = $clog2(INTENS_W + 1);

	localparam logic [CFG_W-1:0]      MAXD_RESET = CFG_W'(10000);
	localparam logic [COUNT_BITS-1:0] COUNT_MAX  = {COUNT_BITS{1'b1}};
	localparam logic [ADDR_W-1:0]     IDX_LAST   = ADDR_W'(DEPTH_BINS - 1);
	localparam logic [CMP_W-1:0]      BINS_CMP   = CMP_W'(DEPTH_BINS);

	localparam logic ACT_ACCUM = 1'b0;
	localparam logic ACT_MAP   = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MAP_RD,
		ST_MAP_OUT,
		ST_ACC_CHK,
		ST_ACC_WR,
		ST_FIN_RD,
		ST_FIN_ACC,
		ST_FIN_LOAD,
		ST_FIN_DIV,
		ST_FIN_WR
	} dhe_state_t;

	typedef struct packed {
		logic start;
		logic in_action;
		logic pix_valid;
		logic last;
		logic fin_zero;
		logic div_done;
	} dhe_stat_t;

	typedef struct packed {
		logic              busy;
		logic              latch;
		logic              use_idx;
		logic              bin_rd;
		logic              bin_wr;
		logic              bin_inc;
		logic              map_rd;
		logic              map_wr;
		logic              map_entry;
		logic              cnt_inc;
		logic              cnt_clr;
		logic              cum_upd;
		logic              div_start;
		logic              out_load;
		logic [ADDR_W-1:0] idx;
	} dhe_ctrl_t;

endpackage

FILE: sv/dhe_div.sv
// Shared restoring divider: quotient bits of floor(256*num/den), one per cycle.
// Depends on dhe_pkg. Requires num <= den and den != 0.
module dhe_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [dhe_pkg::COUNT_BITS-1:0] num,
	input  logic [dhe_pkg::COUNT_BITS-1:0] den,
	output logic [dhe_pkg::INTENS_W-1:0]   quot,
	output logic                          done
);
	import dhe_pkg::*;

	logic [COUNT_BITS:0]   rem_q;
	logic [INTENS_W-1:0]   quot_q;
	logic [STEP_W-1:0]     step_q;
	logic                  run_q;
	logic                  done_q;
	logic                  ge;
	logic [COUNT_BITS:0]   diff;

	assign ge   = rem_q >= {1'b0, den};
	assign diff = ge ? (rem_q - {1'b0, den}) : rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= run_q && !start && (step_q == STEP_W'(1));
			if (start) begin
				run_q  <= 1'b1;
				step_q <= STEP_W'(INTENS_W);
			end else if (run_q) begin
				step_q <= step_q - 1'b1;
				if (step_q == STEP_W'(1)) begin
					run_q  <= 1'b0;
				end
			end
		end
	end

	// remainder stays below den after each subtract, so the shift fits
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= {1'b0, num};
			quot_q <= '0;
		end else if (run_q) begin
			rem_q  <= {diff[COUNT_BITS-1:0], 1'b0};
			quot_q <= {quot_q[INTENS_W-2:0], ge};
		end
	end

	assign quot = quot_q;
	assign done = done_q;

endmodule

FILE: sv/dhe_seq.sv
// Sequencer for the equalizer: clear sweep, pixel steps and the finalize walk.
// Depends on dhe_pkg; drives the datapath in the top level through dhe_ctrl_t.
module dhe_seq (
	input  logic               clk,
	input  logic               arst_n,
	input  dhe_pkg::dhe_stat_t stat,
	output dhe_pkg::dhe_ctrl_t ctrl
);
	import dhe_pkg::*;

	dhe_state_t        state_q, state_d;
	logic [ADDR_W-1:0] idx_q;
	logic              idx_last;

	assign idx_last = idx_q == IDX_LAST;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			if (state_q == ST_CLEAR || state_q == ST_FIN_WR) begin
				idx_q <= idx_last ? '0 : idx_q + 1'b1;
			end
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:    state_d = idx_last ? ST_IDLE : ST_CLEAR;
			ST_IDLE: begin
				if (stat.start) begin
					state_d = (stat.in_action == ACT_MAP) ? ST_MAP_RD : ST_ACC_CHK;
				end
			end
			ST_MAP_RD:   state_d = ST_MAP_OUT;
			ST_MAP_OUT:  state_d = ST_IDLE;
			ST_ACC_CHK: begin
				if (stat.pix_valid) state_d = ST_ACC_WR;
				else state_d = stat.last ? ST_FIN_RD : ST_IDLE;
			end
			ST_ACC_WR:   state_d = stat.last ? ST_FIN_RD : ST_IDLE;
			ST_FIN_RD:   state_d = ST_FIN_ACC;
			ST_FIN_ACC:  state_d = stat.fin_zero ? ST_FIN_WR : ST_FIN_LOAD;
			ST_FIN_LOAD: state_d = ST_FIN_DIV;
			ST_FIN_DIV:  state_d = stat.div_done ? ST_FIN_WR : ST_FIN_DIV;
			ST_FIN_WR:   state_d = idx_last ? ST_IDLE : ST_FIN_RD;
			default:     state_d = ST_CLEAR;
		endcase
	end

	always_comb begin
		ctrl      = '0;
		ctrl.idx  = idx_q;
		ctrl.busy = state_q != ST_IDLE;
		unique case (state_q)
			ST_CLEAR: begin
				ctrl.use_idx = 1'b1;
				ctrl.bin_wr  = 1'b1;
				ctrl.map_wr  = 1'b1;
			end
			ST_IDLE:     ctrl.latch = stat.start;
			ST_MAP_RD:   ctrl.map_rd = 1'b1;
			ST_MAP_OUT:  ctrl.out_load = 1'b1;
			ST_ACC_CHK:  ctrl.bin_rd = stat.pix_valid;
			ST_ACC_WR: begin
				ctrl.bin_wr  = 1'b1;
				ctrl.bin_inc = 1'b1;
				ctrl.cnt_inc = 1'b1;
			end
			ST_FIN_RD: begin
				ctrl.use_idx = 1'b1;
				ctrl.bin_rd  = 1'b1;
			end
			ST_FIN_ACC: begin
				// bin is zeroed for the next frame as it is summed
				ctrl.use_idx = 1'b1;
				ctrl.bin_wr  = 1'b1;
				ctrl.cum_upd = 1'b1;
			end
			ST_FIN_LOAD: ctrl.div_start = 1'b1;
			ST_FIN_DIV:  ctrl.div_start = 1'b0;
			ST_FIN_WR: begin
				ctrl.use_idx   = 1'b1;
				ctrl.map_wr    = 1'b1;
				ctrl.map_entry = 1'b1;
				ctrl.cnt_clr   = idx_last;
			end
			default:     ctrl.busy = 1'b1;
		endcase
	end

endmodule

FILE: sv/depth_histogram_equalizer_unit.sv
// Top level of the depth histogram equalizer: histogram and map memories, datapath.
// Depends on dhe_pkg, dhe_seq and dhe_div.
//
//   channel  | handshake              | payload
//   ---------+------------------------+-----------------------------------
//   pixel in | start, busy            | action, depth_value, last_pixel
//   result   | result_strobe          | intensity, out_of_range
//   config   | cfg_we                 | cfg_wdata (depth limit)
//
// Map pixel: busy through MAP_RD (map read) and MAP_OUT (result load) after start.
// Accumulate pixel: read-modify-write of one bin over a single port (ACC_CHK, ACC_WR).
// Finalize walk over DEPTH_BINS bins after the last pixel: per bin FIN_RD, FIN_ACC,
// FIN_LOAD and FIN_DIV if the shared divider runs its 9 quotient steps, and FIN_WR.
// After reset a clearing sweep over every bin zeroes both memories; busy is high.
// Results cannot be stalled; each beat shows for one cycle.
module depth_histogram_equalizer_unit (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	input  logic                         action,
	input  logic [dhe_pkg::DEPTH_W-1:0]  depth_value,
	input  logic                         last_pixel,
	output logic                         result_strobe,
	output logic [dhe_pkg::INTENS_W-1:0] intensity,
	output logic                         out_of_range,
	input  logic                         cfg_we,
	input  logic [dhe_pkg::CFG_W-1:0]    cfg_wdata
);
	import dhe_pkg::*;

	dhe_stat_t stat;
	dhe_ctrl_t ctrl;

	logic [CFG_W-1:0]      depth_lim_q;
	logic [CMP_W-1:0]      cfg_ext;
	logic [CMP_W-1:0]      limit;
	logic                  in_oor;

	logic [DEPTH_W-1:0]    depth_q;
	logic                  oor_q;
	logic                  pix_valid_q;
	logic                  last_q;

	logic [COUNT_BITS-1:0] cnt_q;
	logic [COUNT_BITS-1:0] cum_q;
	logic                  zero_q;

	logic [COUNT_BITS-1:0] bin_mem [DEPTH_BINS];
	logic [INTENS_W-1:0]   map_mem [DEPTH_BINS];
	logic [COUNT_BITS-1:0] bin_rd_q;
	logic [INTENS_W-1:0]   map_rd_q;
	logic [ADDR_W-1:0]     addr;
	logic [COUNT_BITS-1:0] bin_wdata;
	logic [INTENS_W-1:0]   map_wdata;

	logic                  idx_in_use;
	logic [COUNT_BITS:0]   cum_sum;
	logic [COUNT_BITS-1:0] cum_next;
	logic [INTENS_W-1:0]   quot;
	logic                  div_done;

	logic                  strobe_q;
	logic [INTENS_W-1:0]   intensity_q;
	logic                  oor_out_q;

	// register above the bin count acts as the full bin range
	assign cfg_ext = CMP_W'(depth_lim_q);
	assign limit   = (cfg_ext > BINS_CMP) ? BINS_CMP : cfg_ext;
	assign in_oor  = CMP_W'(depth_value) >= limit;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_lim_q <= MAXD_RESET;
		end else if (cfg_we) begin
			depth_lim_q <= cfg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.latch) begin
			depth_q     <= depth_value;
			oor_q       <= in_oor;
			pix_valid_q <= (depth_value != '0) && !in_oor;
			last_q      <= last_pixel && (action == ACT_ACCUM);
		end
	end

	assign idx_in_use = CMP_W'(ctrl.idx) < limit;

	assign stat.start     = start;
	assign stat.in_action = action;
	assign stat.pix_valid = pix_valid_q;
	assign stat.last      = last_q;
	assign stat.fin_zero  = !idx_in_use || (ctrl.idx == '0) || (cnt_q == '0);
	assign stat.div_done  = div_done;

	dhe_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.stat   (stat),
		.ctrl   (ctrl)
	);

	assign addr      = ctrl.use_idx ? ctrl.idx : ADDR_W'(depth_q);
	assign bin_wdata = !ctrl.bin_inc ? '0 :
	                   (bin_rd_q == COUNT_MAX) ? bin_rd_q : bin_rd_q + 1'b1;
	assign map_wdata = ctrl.map_entry ? (zero_q ? '0 : quot) : '0;

	always_ff @(posedge clk) begin
		if (ctrl.bin_wr) begin
			bin_mem[addr] <= bin_wdata;
		end
		if (ctrl.bin_rd) begin
			bin_rd_q <= bin_mem[addr];
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.map_wr) begin
			map_mem[addr] <= map_wdata;
		end
		if (ctrl.map_rd) begin
			map_rd_q <= map_mem[addr];
		end
	end

	// running sum is clamped to the valid count
	assign cum_sum  = {1'b0, cum_q} + {1'b0, bin_rd_q};
	assign cum_next = (cum_sum > {1'b0, cnt_q}) ? cnt_q : cum_sum[COUNT_BITS-1:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			cum_q <= '0;
		end else begin
			if (ctrl.cnt_clr) begin
				cnt_q <= '0;
				cum_q <= '0;
			end else begin
				if (ctrl.cnt_inc && cnt_q != COUNT_MAX) begin
					cnt_q <= cnt_q + 1'b1;
				end
				if (ctrl.cum_upd && idx_in_use) begin
					cum_q <= cum_next;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.cum_upd) begin
			zero_q <= stat.fin_zero;
		end
	end

	dhe_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (ctrl.div_start),
		.num    (cnt_q - cum_q),
		.den    (cnt_q),
		.quot   (quot),
		.done   (div_done)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= ctrl.out_load;
		end
	end

	always_ff @(posedge clk) begin
		if (ctrl.out_load) begin
			intensity_q <= (depth_q == '0 || oor_q) ? '0 : map_rd_q;
			oor_out_q   <= oor_q;
		end
	end

	assign busy          = ctrl.busy;
	assign result_strobe = strobe_q;
	assign intensity     = intensity_q;
	assign out_of_range  = oor_out_q;

endmodule

FILE: sv/dhe_chk.sv
// Port-level checks for depth_histogram_equalizer_unit, attached by bind.
// Depends on dhe_pkg.
module dhe_chk (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         start,
	input logic                         busy,
	input logic                         action,
	input logic                         result_strobe,
	input logic [dhe_pkg::INTENS_W-1:0] intensity,
	input logic                         out_of_range
);
	import dhe_pkg::*;

	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy not raised after an accepted beat");

	a_accum_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && action == ACT_ACCUM |=> !result_strobe ##1 !result_strobe)
		else $error("result beat after an accumulate pixel");

	a_strobe_single: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |=> !result_strobe)
		else $error("back-to-back result beats");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe && out_of_range |-> intensity == '0)
		else $error("out-of-range pixel with nonzero intensity");

	a_intens_max: assert property (@(posedge clk) disable iff (!arst_n)
		result_strobe |-> intensity <= INTENS_W'(256))
		else $error("intensity above 256");

endmodule

bind depth_histogram_equalizer_unit dhe_chk u_dhe_chk (
	.clk           (clk),
	.arst_n        (arst_n),
	.start         (start),
	.busy          (busy),
	.action        (action),
	.result_strobe (result_strobe),
	.intensity     (intensity),
	.out_of_range  (out_of_range)
);

FILE: dv/depth_histogram_equalizer_unit_tb.sv
// Testbench for depth_histogram_equalizer_unit: accumulate/finalize/map frames, checked beat by beat.
// Depends on dhe_pkg and the depth_histogram_equalizer_unit RTL; needs nothing else.
module depth_histogram_equalizer_unit_tb;
	import dhe_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 4_000_000;

	typedef struct packed {
		logic [INTENS_W-1:0] intensity;
		logic                oor;
	} map_beat_t;

	// Shadow histogram and intensity map, fed every accepted pixel; map pixels queue results.
	class intensity_predictor;
		logic [COUNT_BITS-1:0] bin_cnt [DEPTH_BINS];
		logic [INTENS_W-1:0]   imap [DEPTH_BINS];
		logic [COUNT_BITS-1:0] points;
		logic [CFG_W-1:0]      depth_lim;
		map_beat_t             pending [$];
		int                    errors;

		function new();
			for (int i = 0; i < DEPTH_BINS; i++) begin
				bin_cnt[i] = '0;
				imap[i] = '0;
			end
			points = '0;
			depth_lim = MAXD_RESET;
			errors = 0;
		endfunction

		function void fail_note(string msg);
			errors++;
			if (errors <= 10)
				$display("%0t: %s", $time, msg);
		endfunction

		function void note_pixel(logic act, logic [DEPTH_W-1:0] d, logic last);
			int              lim;
			logic            oor;
			longint unsigned cum;
			longint unsigned pts;
			map_beat_t       beat;
			lim = (int'(depth_lim) > DEPTH_BINS) ? DEPTH_BINS : int'(depth_lim);
			oor = int'(d) >= lim;
			if (act == ACT_MAP) begin
				beat.intensity = (d == 0 || oor) ? '0 : imap[d];
				beat.oor = oor;
				pending = {pending, beat};
			end else begin
				if (d != 0 && !oor) begin
					if (bin_cnt[d] != COUNT_MAX)
						bin_cnt[d]++;
					if (points != COUNT_MAX)
						points++;
				end
				if (last) begin
					// finalize walk: cumulative sum, map entries, clear bins
					pts = points;
					cum = 0;
					for (int i = 0; i < DEPTH_BINS; i++) begin
						imap[i] = '0;
						if (i < lim) begin
							cum += bin_cnt[i];
							if (cum > pts)
								cum = pts;
							if (i != 0 && pts != 0)
								imap[i] = INTENS_W'((256 * (pts - cum)) / pts);
						end
						bin_cnt[i] = '0;
					end
					points = '0;
				end
			end
		endfunction

		function void check_intensity(logic [INTENS_W-1:0] got_i, logic got_oor);
			map_beat_t want;
			if (pending.size() == 0) begin
				fail_note($sformatf("result with nothing expected: intensity %0d oor %0b",
					got_i, got_oor));
			end else begin
				want = pending.pop_front();
				if (got_i !== want.intensity)
					fail_note($sformatf("intensity: expected %0d, got %0d",
						want.intensity, got_i));
				if (got_oor !== want.oor)
					fail_note($sformatf("out_of_range: expected %0b, got %0b",
						want.oor, got_oor));
			end
		endfunction
	endclass

	logic                clk = 1'b0;
	logic                arst_n;
	logic                start;
	logic                busy;
	logic                action;
	logic [DEPTH_W-1:0]  depth_value;
	logic                last_pixel;
	logic                result_strobe;
	logic [INTENS_W-1:0] intensity;
	logic                out_of_range;
	logic                cfg_we;
	logic [CFG_W-1:0]    cfg_wdata;

	intensity_predictor sb = new();
	int                 gap_pct = 0;
	int unsigned        cycles = 0;

	depth_histogram_equalizer_unit DUT (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.action       (action),
		.depth_value  (depth_value),
		.last_pixel   (last_pixel),
		.result_strobe(result_strobe),
		.intensity    (intensity),
		.out_of_range (out_of_range),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata)
	);

	always begin
		clk = 1'b0;
		#5;
		clk = 1'b1;
		#5;
	end

	always @(posedge clk) begin
		if (arst_n === 1'b1 && result_strobe === 1'b1)
			sb.check_intensity(intensity, out_of_range);
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("depth_histogram_equalizer_unit_tb: done, errors");
			$finish;
		end
	end

	// Mostly in range, some near a hot bin, plus zero, out of range and raw noise.
	function automatic int pick_depth(int lim, int hot);
		int r;
		int v;
		r = $urandom_range(0, 9);
		if (lim < 2 || r == 9)
			v = $urandom_range(0, DEPTH_BINS - 1);
		else if (r == 7)
			v = 0;
		else if (r == 8)
			v = (lim >= DEPTH_BINS) ? DEPTH_BINS - 1 : $urandom_range(lim, DEPTH_BINS - 1);
		else if (r >= 4) begin
			v = hot + int'($urandom_range(0, 16)) - 8;
			if (v < 1)
				v = 1;
			if (v > lim - 1)
				v = lim - 1;
		end else
			v = $urandom_range(1, lim - 1);
		return v;
	endfunction

	// Called right after a rising edge; returns at the edge that accepted the beat or after a gap.
	task automatic send_pixel(input logic act, input int d, input logic last);
		start <= 1'b1;
		action <= act;
		depth_value <= DEPTH_W'(d);
		last_pixel <= last;
		@(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		sb.note_pixel(act, DEPTH_W'(d), last);
		if (gap_pct > 0 && $urandom_range(1, 100) <= gap_pct) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 7)) @(posedge clk);
		end
	endtask

	// Drain results, then let a trailing accumulate or finalize walk finish.
	task automatic wait_idle();
		start <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
		while (busy !== 1'b0)
			@(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	task automatic write_depth_lim(input int v);
		cfg_we <= 1'b1;
		cfg_wdata <= CFG_W'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		sb.depth_lim = CFG_W'(v);
	endtask

	// One frame: accumulate pass ending in last_pixel, then a map pass, with noise mixed in.
	task automatic run_frame(input int gap, input int switch_at, input int switch_to);
		int k;
		int m;
		int lim;
		int hot;
		gap_pct = gap;
		lim = (int'(sb.depth_lim) > DEPTH_BINS) ? DEPTH_BINS : int'(sb.depth_lim);
		hot = (lim > 1) ? $urandom_range(1, lim - 1) : 1;
		k = $urandom_range(50, 100);
		for (int i = 0; i < k; i++) begin
			if (i == switch_at) begin
				// new depth limit mid-pass: counts so far stay in their bins
				wait_idle();
				write_depth_lim(switch_to);
				lim = (int'(sb.depth_lim) > DEPTH_BINS) ? DEPTH_BINS : int'(sb.depth_lim);
				hot = (lim > 1) ? $urandom_range(1, lim - 1) : 1;
			end
			if (i == k - 1)
				send_pixel(ACT_ACCUM, pick_depth(lim, hot), 1'b1);
			else if ($urandom_range(0, 9) == 0)
				send_pixel(ACT_MAP, pick_depth(lim, hot), 1'($urandom_range(0, 1)));
			else
				send_pixel(ACT_ACCUM, pick_depth(lim, hot), 1'b0);
		end
		m = $urandom_range(50, 100);
		for (int i = 0; i < m; i++) begin
			// stray accumulate beats carry over into the next frame
			if ($urandom_range(0, 9) == 0)
				send_pixel(ACT_ACCUM, pick_depth(lim, hot), 1'b0);
			else
				send_pixel(ACT_MAP, pick_depth(lim, hot), 1'($urandom_range(0, 1)));
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		start <= 1'b0;
		action <= ACT_ACCUM;
		depth_value <= '0;
		last_pixel <= 1'b0;
		cfg_we <= 1'b0;
		cfg_wdata <= '0;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// map before any finalize, reset depth limit; last_pixel on a map beat is ignored
		send_pixel(ACT_MAP, 0, 1'b1);
		send_pixel(ACT_MAP, 1, 1'b0);
		send_pixel(ACT_MAP, 9999, 1'b0);
		send_pixel(ACT_MAP, 10000, 1'b0);
		send_pixel(ACT_MAP, DEPTH_BINS - 1, 1'b0);
		send_pixel(ACT_ACCUM, 0, 1'b0);
		send_pixel(ACT_ACCUM, 1, 1'b0);
		send_pixel(ACT_ACCUM, 1, 1'b0);
		send_pixel(ACT_ACCUM, 5, 1'b0);
		send_pixel(ACT_ACCUM, 9999, 1'b0);
		send_pixel(ACT_ACCUM, 10000, 1'b0);
		send_pixel(ACT_ACCUM, DEPTH_BINS - 1, 1'b0);
		send_pixel(ACT_ACCUM, 3, 1'b1);
		send_pixel(ACT_MAP, 1, 1'b0);
		send_pixel(ACT_MAP, 3, 1'b0);
		send_pixel(ACT_MAP, 5, 1'b0);
		send_pixel(ACT_MAP, 9999, 1'b0);

		// depth limit 0: even zero depth reads out of range
		wait_idle();
		write_depth_lim(0);
		send_pixel(ACT_MAP, 0, 1'b0);
		send_pixel(ACT_MAP, 5, 1'b0);

		// register above the bin count acts as full range
		wait_idle();
		write_depth_lim(2 ** CFG_W - 1);
		send_pixel(ACT_ACCUM, DEPTH_BINS - 1, 1'b0);
		send_pixel(ACT_ACCUM, 1, 1'b0);
		send_pixel(ACT_ACCUM, 8191, 1'b0);
		send_pixel(ACT_ACCUM, DEPTH_BINS - 1, 1'b1);
		send_pixel(ACT_MAP, DEPTH_BINS - 1, 1'b0);
		send_pixel(ACT_MAP, 8191, 1'b0);
		send_pixel(ACT_MAP, 1, 1'b0);

		// frame 0 has no countable pixels; small ranges keep finalize walks short
		for (int f = 0; f < 7; f++) begin
			wait_idle();
			write_depth_lim(f == 0 ? 1 : (f == 1 ? 2 : $urandom_range(3, 700)));
			run_frame(f < 5 ? $urandom_range(0, 40) : 0, f == 3 ? 30 : -1,
				$urandom_range(3, 700));
		end

		wait_idle();
		repeat (20) @(posedge clk);
		if (sb.pending.size() != 0)
			sb.fail_note($sformatf("%0d expected results never arrived", sb.pending.size()));
		if (sb.errors == 0) begin
			$display("depth_histogram_equalizer_unit_tb: done, clean");
		end else begin
			$display("depth_histogram_equalizer_unit_tb: done, errors");
		end
		$finish;
	end

endmodule

FILE: filelist.f
sv/dhe_pkg.sv
sv/dhe_div.sv
sv/dhe_seq.sv
sv/depth_histogram_equalizer_unit.sv
sv/dhe_chk.sv
dv/depth_histogram_equalizer_unit_tb.sv
